[hdl/hll_pkg.sv]
// Shared types, constants and helpers of the HyperLogLog sketch estimator.
package hll_pkg;

    localparam int CFG_W              = 4;
    localparam int HASH_W             = 32;
    localparam int OUT_W              = 40;
    localparam int RANK_W             = 4;
    localparam int HIST_BINS          = 16;
    localparam int MIN_INDEX_BITS     = 4;
    localparam int DEF_MAX_INDEX_BITS = 14;
    localparam int RANK_SCAN          = 14;
    localparam int LOG_FRAC           = 30;
    localparam int D_W                = 36;
    localparam int ACC_W              = 64;

    localparam logic [CFG_W-1:0]  RESET_INDEX_BITS = 4'd14;
    localparam logic [RANK_W-1:0] RANK_MAX         = 4'd15;
    localparam logic [12:0]       ALPHA_NUM        = 13'd7213;
    localparam int                C_MUL            = 10000;
    localparam int                C_ADD            = 10790;
    localparam int                DIV_SHIFT        = 23;
    localparam logic [27:0]       LN2_Q28          = 28'd186065280;
    localparam logic [5:0]        LARGE_LOG_INT    = 6'd40;

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_ESTIMATE = 2'd1,
        REQ_CLEAR    = 2'd2,
        REQ_NOP      = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SUM,
        S_MULT,
        S_DIV,
        S_DECIDE,
        S_NORM,
        S_SQUARE,
        S_LN_LO,
        S_LN_HI,
        S_FINISH,
        S_DONE
    } t_state;

    function automatic logic [4:0] clamp_bits(input logic [CFG_W-1:0] v,
                                              input logic [4:0] max_bits);
        logic [4:0] p;
        begin
            p = {1'b0, v};
            if (p < 5'(MIN_INDEX_BITS)) p = 5'(MIN_INDEX_BITS);
            if (p > max_bits) p = max_bits;
            return p;
        end
    endfunction

endpackage

[hdl/hll_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hll_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/hyperloglog_sketch_estimator.sv]
// HyperLogLog sketch: rank store, value histogram and estimate sequencer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall| i_req_type, i_hash_value
//  out     | output    | o_out_valid/i_out_stall| o_estimate_valid, o_cardinality_estimate,
//          |           |                        | o_estimate_saturated
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_data (index_bits)
//
// Inserts and no-ops transfer one per cycle unless the input stalls; the rank RAM
// read-modify-write is split over a read and a write stage with forwarding of the
// previous write. Estimates and clears wait while an insert is in its write stage.
// An estimate runs the bit-serial 128-step divider, and when a log step runs, it also
// normalizes and takes 30 squaring steps. Reset, a clear request and a cfg write each
// start a clear pass over all 2^MAX_INDEX_BITS rank RAM entries; no item is taken meanwhile.
// A result held under output stall blocks the input side until it transfers.
module hyperloglog_sketch_estimator #(
    parameter int MAX_INDEX_BITS = hll_pkg::DEF_MAX_INDEX_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_req_type,
    input  logic [hll_pkg::HASH_W-1:0] i_hash_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_estimate_valid,
    output logic [hll_pkg::OUT_W-1:0] o_cardinality_estimate,
    output logic                      o_estimate_saturated,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [hll_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int DEPTH = 1 << MAX_INDEX_BITS;
    localparam int AW    = MAX_INDEX_BITS;
    localparam int HW    = MAX_INDEX_BITS + 1;
    localparam int SW    = MAX_INDEX_BITS + 16;
    localparam int CW    = MAX_INDEX_BITS + 15;
    localparam int DW    = CW + SW;
    localparam int RW    = DW + 1;
    localparam int OW    = hll_pkg::OUT_W;
    localparam int RK    = hll_pkg::RANK_W;

    hll_pkg::t_state r_state, n_state;

    logic [hll_pkg::CFG_W-1:0] r_index_bits;
    logic [4:0] p_cur, p_cfg, p_clr;

    logic out_free, in_ready, in_acc, cfg_acc;
    hll_pkg::t_req req;

    // insert pipeline
    logic          r_b_valid;
    logic [AW-1:0] r_b_slot;
    logic [RK-1:0] r_b_rank;
    logic          r_fw_valid;
    logic [AW-1:0] r_fw_slot;
    logic [RK-1:0] r_fw_val;
    logic [RK-1:0] ram_rdata, old_rank, ins_rank;
    logic [AW-1:0] ins_slot;
    logic [31:0]   sh_hash, slot_full;
    logic          upd;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RK-1:0] ram_wdata;
    logic [AW-1:0] r_clr_addr;

    logic [HW-1:0] r_hist [hll_pkg::HIST_BINS];

    // estimate datapath
    logic [6:0]     r_cnt;
    logic [SW-1:0]  r_s;
    logic [DW-1:0]  r_den;
    logic [RW-1:0]  r_rem;
    logic [OW-1:0]  r_q;
    logic           r_over;
    logic           r_mode_lin;
    logic [OW-1:0]  r_x;
    logic [5:0]     r_sh;
    logic [30:0]    r_z;
    logic [29:0]    r_frac;
    logic [hll_pkg::D_W-1:0]   r_d;
    logic [hll_pkg::ACC_W-1:0] r_acc;
    logic [OW-1:0]  r_res;
    logic           r_sat;

    logic [SW-1:0]  sum_term;
    logic [CW-1:0]  c_val;
    logic [DW-1:0]  den_prod;
    logic [6:0]     div_off, div_idx;
    logic           div_bit, div_ge;
    logic [RW-1:0]  rem_sh;
    logic [OW-1:0]  lin_lim;
    logic [OW+4:0]  q30;
    logic           lin_sel, large_sel;
    logic [OW:0]    x_large;
    logic [61:0]    zz;
    logic [31:0]    zt;
    logic [hll_pkg::D_W-1:0] log_val, log_base, d_val;
    logic [45:0]    prod_lo, prod_hi;
    logic [29:0]    q24;
    logic [55:0]    lin_tmp;

    logic          r_o_valid, r_o_est, r_o_sat;
    logic [OW-1:0] r_o_card;

    assign p_cur = hll_pkg::clamp_bits(r_index_bits, 5'(MAX_INDEX_BITS));
    assign p_cfg = hll_pkg::clamp_bits(i_cfg_data, 5'(MAX_INDEX_BITS));
    assign p_clr = cfg_acc ? p_cfg : p_cur;
    assign req   = hll_pkg::t_req'(i_req_type);

    assign out_free = !r_o_valid || !i_out_stall;
    assign in_ready = (r_state == hll_pkg::S_IDLE) && out_free && !i_cfg_valid &&
                      (req == hll_pkg::REQ_INSERT || req == hll_pkg::REQ_NOP || !r_b_valid);
    assign in_acc   = i_in_valid && in_ready;
    assign o_in_stall  = !in_ready;
    assign o_cfg_ready = (r_state == hll_pkg::S_IDLE) && !r_b_valid;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;

    // slot from the top p bits, rank from the leading zeros of the rest
    assign slot_full = i_hash_value >> (6'd32 - {1'b0, p_cur});
    assign ins_slot  = slot_full[AW-1:0];
    assign sh_hash   = i_hash_value << p_cur;

    always_comb begin
        ins_rank = hll_pkg::RANK_MAX;
        for (int j = hll_pkg::RANK_SCAN - 1; j >= 0; j--) begin
            if (sh_hash[31-j]) ins_rank = RK'(j + 1);
        end
    end

    assign old_rank = (r_fw_valid && r_fw_slot == r_b_slot) ? r_fw_val : ram_rdata;
    assign upd      = r_b_valid && (r_b_rank > old_rank);

    always_comb begin
        if (r_state == hll_pkg::S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = upd;
            ram_waddr = r_b_slot;
            ram_wdata = r_b_rank;
        end
    end

    hll_ram #(
        .WIDTH (RK),
        .DEPTH (DEPTH)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ins_slot),
        .o_rdata (ram_rdata)
    );

    // estimate arithmetic
    assign sum_term = SW'(r_hist[r_cnt[3:0]]) << (4'd15 - r_cnt[3:0]);
    assign c_val    = (CW'(hll_pkg::C_MUL) << p_cur) + CW'(hll_pkg::C_ADD);
    assign den_prod = c_val * r_s;

    assign div_off = 7'(3 * p_cur + hll_pkg::DIV_SHIFT);
    assign div_idx = r_cnt - div_off;
    assign div_bit = (r_cnt >= div_off) && (div_idx < 7'd13) ?
                     hll_pkg::ALPHA_NUM[div_idx[3:0]] : 1'b0;
    assign rem_sh  = {r_rem[RW-2:0], div_bit};
    assign div_ge  = rem_sh >= {1'b0, r_den};

    assign lin_lim   = OW'(640) << p_cur;
    assign q30       = ({5'd0, r_q} << 5) - ({5'd0, r_q} << 1);
    assign lin_sel   = (r_hist[0] != '0) && (r_q <= lin_lim);
    assign large_sel = q30 > ((OW+5)'(1) << OW);
    assign x_large   = ((OW+1)'(1) << OW) - {1'b0, r_q};

    assign zz = {31'd0, r_z} * {31'd0, r_z};
    assign zt = zz[61:30];

    assign log_val  = {6'd39 - r_sh, r_frac};
    assign log_base = r_mode_lin ? {1'b0, p_cur, 30'd0} : {hll_pkg::LARGE_LOG_INT, 30'd0};
    assign d_val    = (log_base > log_val) ? log_base - log_val : '0;
    assign prod_lo  = {28'd0, d_val[17:0]} * {18'd0, hll_pkg::LN2_Q28};
    assign prod_hi  = {28'd0, r_d[35:18]} * {18'd0, hll_pkg::LN2_Q28};
    assign q24      = r_acc[63:34];
    assign lin_tmp  = {26'd0, q24} << p_cur;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hll_pkg::S_IDLE: begin
                if (cfg_acc) begin
                    n_state = hll_pkg::S_CLEAR;
                end else if (in_acc && req == hll_pkg::REQ_ESTIMATE) begin
                    n_state = hll_pkg::S_SUM;
                end else if (in_acc && req == hll_pkg::REQ_CLEAR) begin
                    n_state = hll_pkg::S_CLEAR;
                end
            end
            hll_pkg::S_CLEAR: begin
                if (r_clr_addr == '1) n_state = hll_pkg::S_IDLE;
            end
            hll_pkg::S_SUM: begin
                if (r_cnt[3:0] == 4'hF) n_state = hll_pkg::S_MULT;
            end
            hll_pkg::S_MULT: begin
                n_state = (r_s == '0) ? hll_pkg::S_DONE : hll_pkg::S_DIV;
            end
            hll_pkg::S_DIV: begin
                if (r_cnt == '0) n_state = hll_pkg::S_DECIDE;
            end
            hll_pkg::S_DECIDE: begin
                if (r_over) n_state = hll_pkg::S_DONE;
                else if (lin_sel || large_sel) n_state = hll_pkg::S_NORM;
                else n_state = hll_pkg::S_DONE;
            end
            hll_pkg::S_NORM: begin
                if (r_x[OW-1]) n_state = hll_pkg::S_SQUARE;
            end
            hll_pkg::S_SQUARE: begin
                if (r_cnt == 7'(hll_pkg::LOG_FRAC - 1)) n_state = hll_pkg::S_LN_LO;
            end
            hll_pkg::S_LN_LO:  n_state = hll_pkg::S_LN_HI;
            hll_pkg::S_LN_HI:  n_state = hll_pkg::S_FINISH;
            hll_pkg::S_FINISH: n_state = hll_pkg::S_DONE;
            hll_pkg::S_DONE: begin
                if (out_free) n_state = hll_pkg::S_IDLE;
            end
            default: n_state = hll_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hll_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control: config, insert pipeline, clear sweep, histogram, output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= hll_pkg::RESET_INDEX_BITS;
            r_b_valid    <= 1'b0;
            r_fw_valid   <= 1'b0;
            r_clr_addr   <= '0;
            r_o_valid    <= 1'b0;
            for (int k = 0; k < hll_pkg::HIST_BINS; k++) begin
                r_hist[k] <= '0;
            end
            r_hist[0] <= HW'(1) << hll_pkg::clamp_bits(hll_pkg::RESET_INDEX_BITS,
                                                      5'(MAX_INDEX_BITS));
        end else begin
            r_b_valid  <= in_acc && req == hll_pkg::REQ_INSERT;
            r_fw_valid <= upd;
            if (cfg_acc) r_index_bits <= i_cfg_data;

            if (r_state == hll_pkg::S_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            else r_clr_addr <= '0;

            if (cfg_acc || (in_acc && req == hll_pkg::REQ_CLEAR)) begin
                for (int k = 0; k < hll_pkg::HIST_BINS; k++) begin
                    r_hist[k] <= '0;
                end
                r_hist[0] <= HW'(1) << p_clr;
            end else begin
                for (int k = 0; k < hll_pkg::HIST_BINS; k++) begin
                    r_hist[k] <= r_hist[k]
                        + HW'(upd && r_b_rank == RK'(k))
                        - HW'(upd && old_rank == RK'(k) && r_hist[k] != '0);
                end
            end

            if (in_acc && req != hll_pkg::REQ_ESTIMATE) begin
                r_o_valid <= 1'b1;
            end else if (r_state == hll_pkg::S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_slot <= ins_slot;
            r_b_rank <= ins_rank;
        end
        r_fw_slot <= r_b_slot;
        r_fw_val  <= r_b_rank;

        if (in_acc && req != hll_pkg::REQ_ESTIMATE) begin
            r_o_est  <= 1'b0;
            r_o_card <= '0;
            r_o_sat  <= 1'b0;
        end else if (r_state == hll_pkg::S_DONE && out_free) begin
            r_o_est  <= 1'b1;
            r_o_card <= r_res;
            r_o_sat  <= r_sat;
        end

        case (r_state)
            hll_pkg::S_IDLE: begin
                r_cnt <= '0;
                r_s   <= '0;
            end
            hll_pkg::S_SUM: begin
                r_s   <= r_s + sum_term;
                r_cnt <= r_cnt + 1'b1;
            end
            hll_pkg::S_MULT: begin
                r_den  <= den_prod;
                r_cnt  <= 7'd127;
                r_rem  <= '0;
                r_q    <= '0;
                r_over <= 1'b0;
                r_res  <= '1;
                r_sat  <= 1'b1;
            end
            hll_pkg::S_DIV: begin
                if (div_ge) begin
                    r_rem <= rem_sh - {1'b0, r_den};
                    if (r_cnt >= 7'(OW)) r_over <= 1'b1;
                    else r_q[r_cnt[5:0]] <= 1'b1;
                end else begin
                    r_rem <= rem_sh;
                end
                r_cnt <= r_cnt - 1'b1;
            end
            hll_pkg::S_DECIDE: begin
                r_sh <= '0;
                if (r_over) begin
                    r_res <= '1;
                    r_sat <= 1'b1;
                end else if (lin_sel) begin
                    r_mode_lin <= 1'b1;
                    r_x        <= OW'(r_hist[0]);
                end else if (large_sel) begin
                    r_mode_lin <= 1'b0;
                    r_x        <= x_large[OW-1:0];
                end else begin
                    r_res <= r_q;
                    r_sat <= 1'b0;
                end
            end
            hll_pkg::S_NORM: begin
                // normalize so the top set bit lands on bit 39
                if (!r_x[OW-1]) begin
                    r_x  <= r_x << 1;
                    r_sh <= r_sh + 1'b1;
                end else begin
                    r_z    <= r_x[OW-1:9];
                    r_frac <= '0;
                    r_cnt  <= '0;
                end
            end
            hll_pkg::S_SQUARE: begin
                if (zt[31]) begin
                    r_z    <= zt[31:1];
                    r_frac <= {r_frac[28:0], 1'b1};
                end else begin
                    r_z    <= zt[30:0];
                    r_frac <= {r_frac[28:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            hll_pkg::S_LN_LO: begin
                r_d   <= d_val;
                r_acc <= {18'd0, prod_lo};
            end
            hll_pkg::S_LN_HI: begin
                r_acc <= r_acc + ({18'd0, prod_hi} << 18);
            end
            hll_pkg::S_FINISH: begin
                if (r_mode_lin) begin
                    r_res <= lin_tmp[55:16];
                    r_sat <= 1'b0;
                end else if (q24[29:24] != '0) begin
                    r_res <= '1;
                    r_sat <= 1'b1;
                end else begin
                    r_res <= {q24[23:0], 16'd0};
                    r_sat <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid            = r_o_valid;
    assign o_estimate_valid       = r_o_est;
    assign o_cardinality_estimate = r_o_card;
    assign o_estimate_saturated   = r_o_sat;

endmodule

[hdl/hll_checker.sv]
// Port-level checks of the HyperLogLog sketch estimator, bound to the top level.
module hll_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_estimate_valid,
    input logic [hll_pkg::OUT_W-1:0] o_cardinality_estimate,
    input logic                      o_estimate_saturated
);

    // a register write starts the clear sweep, so inputs hold off next cycle
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> o_in_stall)
        else $error("input taken right after cfg transfer");

    a_plain_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_estimate_valid |->
            o_cardinality_estimate == '0 && !o_estimate_saturated)
        else $error("non-estimate result carries a value");

    a_sat_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_estimate_saturated |-> o_cardinality_estimate == '1)
        else $error("saturated estimate not clamped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cardinality_estimate))
        else $error("stalled result changed");

endmodule

bind hyperloglog_sketch_estimator hll_checker u_hll_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_cfg_valid            (i_cfg_valid),
    .o_cfg_ready            (o_cfg_ready),
    .o_in_stall             (o_in_stall),
    .o_out_valid            (o_out_valid),
    .i_out_stall            (i_out_stall),
    .o_estimate_valid       (o_estimate_valid),
    .o_cardinality_estimate (o_cardinality_estimate),
    .o_estimate_saturated   (o_estimate_saturated)
);
